[hw/rtl/serial_line_button_parser_assert.svh]
// ---------------------------------------------------------------------------
// serial line button parser assertion macros
// shared concurrent assertion forms used by the rtl modules
// ---------------------------------------------------------------------------
`ifndef SERIAL_LINE_BUTTON_PARSER_ASSERT_SVH
`define SERIAL_LINE_BUTTON_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SLBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/slbp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// slbp_pkg
// shared types and constants of the serial line button parser
// ---------------------------------------------------------------------------
package slbp_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_0     = 8'd48;
	localparam logic [7:0] CH_9     = 8'd57;

	// accumulator saturation value, anything above the byte range
	localparam logic [8:0] ACC_SAT = 9'd256;

	// result kinds
	localparam logic KIND_BUTTON = 1'b0;
	localparam logic KIND_INFO   = 1'b1;

	// widths sized for the largest supported line capacity (65)
	localparam int LEN_W_MAX = 7;
	localparam int IDX_W_MAX = 6;

	// job queue depth between front and back
	localparam int JOBQ_DEPTH = 2;

	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_BAD    = 2'd3
	} phase_t;

	typedef enum logic {
		BK_IDLE  = 1'b0,
		BK_DRAIN = 1'b1
	} back_state_t;

	// line store write port, front to back
	typedef struct packed {
		logic                 en;
		logic                 bank;
		logic [IDX_W_MAX-1:0] idx;
		logic [7:0]           data;
	} store_wr_t;

	// one finished line
	typedef struct packed {
		logic                 ok;
		logic [7:0]           mask;
		logic                 bank;
		logic [LEN_W_MAX-1:0] tlen;
	} job_t;

	// store bank handed back once its text has been streamed out
	typedef struct packed {
		logic en;
		logic bank;
	} bank_rel_t;

endpackage
`default_nettype wire

[hw/rtl/slbp_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// slbp channel interfaces
// valid/ready channels for received bytes and for results
// ---------------------------------------------------------------------------
interface slbp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slbp_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value;
	logic       last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/serial_line_button_parser.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// serial_line_button_parser
// collects received bytes into lines and reports a button mask or echo text
// ---------------------------------------------------------------------------
// rx  : one received byte per transaction; CR or LF ends the line
// res : results {kind, value, last}; kind 0 carries a button mask, kind 1
//       one byte of the line text, last marks the final one of a line
// throughput: bytes are taken one per cycle while the two-entry line queue
//   has room and the store bank being filled is free; info text leaves at
//   one byte per cycle through the single store read port while res is ready,
//   a mask as one transaction; with the back idle a line end passes the line
//   queue and the output register before the first result of its line is valid
// stalls: a held res keeps its transaction and freezes the drain; rx keeps
//   filling the second store bank until the queue fills or the next line
//   needs the bank still being drained
// reset: arst_n clears all control state and empties the queue; the line
//   store needs no clearing, only bytes written for the current line are read
// ---------------------------------------------------------------------------

module serial_line_button_parser #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	slbp_rx_if.sink    rx,
	slbp_res_if.source res
);
	import slbp_pkg::*;

	// between front and back: store writes, bank release and the line queue
	store_wr_t wr;
	bank_rel_t rel;
	job_t      push_job;
	job_t      head;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	// front: byte acceptance, line store writes, incremental number check
	slbp_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.rel    (rel),
		.q_full (q_full),
		.wr     (wr),
		.push   (push),
		.job    (push_job)
	);

	// finished lines wait here so front and back stall on their own
	slbp_job_fifo u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: line store and result sequencing
	slbp_back #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.rel     (rel),
		.res     (res)
	);

endmodule
`default_nettype wire

[hw/rtl/slbp_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// slbp_front
// accepts bytes, stores the line and checks the number as it arrives
// ---------------------------------------------------------------------------
`include "serial_line_button_parser_assert.svh"

module slbp_front #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	slbp_rx_if.sink             rx,
	input  slbp_pkg::bank_rel_t rel,
	input  logic                q_full,
	output slbp_pkg::store_wr_t wr,
	output logic                push,
	output slbp_pkg::job_t      job
);
	import slbp_pkg::*;

	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int LW    = $clog2(LINE_CAPACITY);

	logic [LW-1:0] len_q;
	logic [LW-1:0] text_end_q;
	logic          zero_seen_q;
	phase_t        phase_q;
	logic          minus_q;
	logic [8:0]    accum_q;
	logic          bank_q;
	logic [1:0]    busy_q;

	phase_t        phase_n;
	logic          minus_n;
	logic [8:0]    accum_n;
	logic [1:0]    busy_n;
	logic [12:0]   acc_wide;
	logic          accept;
	logic          is_eol;
	logic          is_space;
	logic          is_sign;
	logic          is_digit;
	logic          has_room;
	logic          store;
	logic          eol;
	logic          ok;
	logic [LW-1:0] tlen;

	assign rx.ready = !busy_q[bank_q] && !q_full;
	assign accept   = rx.valid && rx.ready;
	assign is_eol   = (rx.rx_byte == CH_LF) || (rx.rx_byte == CH_CR);
	assign is_space = rx.rx_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
	assign is_sign  = (rx.rx_byte == CH_PLUS) || (rx.rx_byte == CH_MINUS);
	assign is_digit = rx.rx_byte inside {[CH_0:CH_9]};
	assign has_room = len_q < LW'(DEPTH);
	assign store    = accept && !is_eol && has_room;
	assign eol      = accept && is_eol;

	assign acc_wide = 13'(accum_q) * 13'd10 + 13'(rx.rx_byte - CH_0);

	// per-byte number check, stops at the first zero byte
	always_comb begin
		phase_n = phase_q;
		minus_n = minus_q;
		accum_n = accum_q;
		if (store && !zero_seen_q && rx.rx_byte != CH_NUL) begin
			if (phase_q == PH_SPACE && is_space) begin
				phase_n = phase_q;
			end else if (phase_q == PH_SPACE && is_sign) begin
				minus_n = (rx.rx_byte == CH_MINUS);
				phase_n = PH_SIGN;
			end else if (phase_q != PH_BAD) begin
				if (is_digit) begin
					accum_n = (acc_wide > 13'd255) ? ACC_SAT : acc_wide[8:0];
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_BAD;
				end
			end
		end
	end

	assign tlen = zero_seen_q ? text_end_q : len_q;
	assign ok   = (phase_q == PH_DIGITS) && (minus_q ? (accum_q == 9'd0) : !accum_q[8]);
	assign push = eol && (len_q != '0) && (ok || tlen != '0);

	assign job.ok   = ok;
	assign job.mask = accum_q[7:0];
	assign job.bank = bank_q;
	assign job.tlen = LEN_W_MAX'(tlen);

	assign wr.en   = store;
	assign wr.bank = bank_q;
	assign wr.idx  = IDX_W_MAX'(len_q);
	assign wr.data = rx.rx_byte;

	always_comb begin
		busy_n = busy_q;
		if (rel.en) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (push && !ok) begin
			busy_n[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			text_end_q  <= '0;
			zero_seen_q <= 1'b0;
			phase_q     <= PH_SPACE;
			minus_q     <= 1'b0;
			accum_q     <= '0;
			bank_q      <= 1'b0;
			busy_q      <= '0;
		end else begin
			busy_q <= busy_n;
			if (eol) begin
				len_q       <= '0;
				text_end_q  <= '0;
				zero_seen_q <= 1'b0;
				phase_q     <= PH_SPACE;
				minus_q     <= 1'b0;
				accum_q     <= '0;
				if (push && !ok) begin
					bank_q <= !bank_q;
				end
			end else if (store) begin
				len_q   <= len_q + LW'(1);
				phase_q <= phase_n;
				minus_q <= minus_n;
				accum_q <= accum_n;
				if (!zero_seen_q && rx.rx_byte == CH_NUL) begin
					zero_seen_q <= 1'b1;
					text_end_q  <= len_q;
				end
			end
		end
	end

	`SLBP_ASSERT_IMP(a_write_free_bank, clk, arst_n, wr.en, !busy_q[wr.bank], "slbp_front: write into busy bank")
	`SLBP_ASSERT_IMP(a_busy_bank_released, clk, arst_n, rel.en, busy_q[rel.bank], "slbp_front: release of idle bank")
	`SLBP_ASSERT_IMP(a_len_bound, clk, arst_n, 1'b1, len_q <= LW'(DEPTH), "slbp_front: line length past capacity")

endmodule
`default_nettype wire

[hw/rtl/slbp_job_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// slbp_job_fifo
// short queue of finished lines between front and back
// ---------------------------------------------------------------------------
`include "serial_line_button_parser_assert.svh"

module slbp_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slbp_pkg::job_t push_job,
	input  logic           pop,
	output slbp_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import slbp_pkg::*;

	localparam int PW = $clog2(JOBQ_DEPTH);

	job_t        ent_q [JOBQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   count_q;

	assign full  = count_q == (PW+1)'(JOBQ_DEPTH);
	assign empty = count_q == '0;
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(JOBQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(JOBQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	`SLBP_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full, "slbp_job_fifo: push while full")
	`SLBP_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty, "slbp_job_fifo: pop while empty")
	`SLBP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= (PW+1)'(JOBQ_DEPTH), "slbp_job_fifo: count past depth")

endmodule
`default_nettype wire

[hw/rtl/slbp_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// slbp_back
// holds the line store and turns queued lines into result transactions
// ---------------------------------------------------------------------------
`include "serial_line_button_parser_assert.svh"

module slbp_back #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slbp_pkg::store_wr_t wr,
	input  slbp_pkg::job_t      head,
	input  logic                q_empty,
	output logic                pop,
	output slbp_pkg::bank_rel_t rel,
	slbp_res_if.source          res
);
	import slbp_pkg::*;

	localparam int DEPTH        = LINE_CAPACITY - 1;
	localparam int LW           = $clog2(LINE_CAPACITY);
	localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BANK_ENTRIES = 2 ** AW;

	// two banks, one being filled while the other drains
	logic [7:0]    mem [2 * BANK_ENTRIES];

	back_state_t   state_q;
	back_state_t   state_n;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] tlen_q;
	logic          bank_q;
	logic          out_valid_q;
	logic          kind_q;
	logic [7:0]    value_q;
	logic          last_q;

	logic          slot_free;
	logic          load_btn;
	logic          load_info;
	logic          info_last;
	logic          start_drain;
	logic [AW:0]   rd_addr;

	assign slot_free = !out_valid_q || res.ready;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		pop         = 1'b0;
		load_btn    = 1'b0;
		load_info   = 1'b0;
		info_last   = 1'b0;
		start_drain = 1'b0;
		rel         = '0;
		rd_addr     = {bank_q, idx_q[AW-1:0]};
		case (state_q)
			BK_IDLE: begin
				rd_addr = {head.bank, AW'(0)};
				if (!q_empty && slot_free) begin
					pop = 1'b1;
					if (head.ok) begin
						load_btn = 1'b1;
					end else begin
						load_info = 1'b1;
						info_last = head.tlen == LEN_W_MAX'(1);
						if (info_last) begin
							rel.en   = 1'b1;
							rel.bank = head.bank;
						end else begin
							start_drain = 1'b1;
							state_n     = BK_DRAIN;
						end
					end
				end
			end
			BK_DRAIN: begin
				if (slot_free) begin
					load_info = 1'b1;
					info_last = (idx_q + LW'(1)) == tlen_q;
					if (info_last) begin
						rel.en   = 1'b1;
						rel.bank = bank_q;
						state_n  = BK_IDLE;
					end
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			tlen_q      <= '0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_drain) begin
				idx_q  <= LW'(1);
				tlen_q <= LW'(head.tlen);
				bank_q <= head.bank;
			end else if (load_info) begin
				idx_q <= idx_q + LW'(1);
			end
			if (load_btn || load_info) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register doubles as the store read register
	always_ff @(posedge clk) begin
		if (load_btn) begin
			kind_q  <= KIND_BUTTON;
			value_q <= head.mask;
			last_q  <= 1'b1;
		end else if (load_info) begin
			kind_q  <= KIND_INFO;
			value_q <= mem[rd_addr];
			last_q  <= info_last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.kind  = kind_q;
	assign res.value = value_q;
	assign res.last  = last_q;

	`SLBP_ASSERT_IMP(a_drain_idx, clk, arst_n, state_q == BK_DRAIN, idx_q < tlen_q, "slbp_back: drain index past text end")
	`SLBP_ASSERT_NEXT(a_stall_holds_drain, clk, arst_n, state_q == BK_DRAIN && out_valid_q && !res.ready, state_q == BK_DRAIN && $stable(idx_q), "slbp_back: drain moved while stalled")
	`SLBP_ASSERT_IMP(a_release_on_last, clk, arst_n, rel.en, load_info && info_last, "slbp_back: bank released before last byte")

endmodule
`default_nettype wire
